[hw/rtl/ptp_layer2_frame_filter_defines.svh]
// ----------------------------------------------------------------------------
// PTP layer-2 frame filter assertion macros
// Concurrent assertion helpers shared by the filter RTL, clocked on i_clk and
// disabled while i_rst_n is low. Defining NO_ASSERTIONS empties them.
// ----------------------------------------------------------------------------
`ifndef PTP_LAYER2_FRAME_FILTER_DEFINES_SVH
`define PTP_LAYER2_FRAME_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PTPFF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PTPFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define PTPFF_ASSERT_NOW(lbl, ante, cons, msg)
`define PTPFF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/ptpl2ff_pkg.sv]
// ----------------------------------------------------------------------------
// PTP layer-2 frame filter package
// Payload types, verdict codes, register indices and the fixed constants of
// the IEEE 1588 Annex F Ethernet transport.
// ----------------------------------------------------------------------------
package ptpl2ff_pkg;

    localparam int LEN_W = 14;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       verdict;
        logic             to_peer_address;
        logic             vlan_tagged;
        logic [15:0]      ether_type;
        logic [4:0]       payload_offset;
        logic [6:0]       payload_length;
        logic [LEN_W-1:0] frame_length;
    } t_out_item;

    // Verdict codes.
    localparam logic [2:0] VERDICT_ACCEPT     = 3'd0;
    localparam logic [2:0] VERDICT_TOO_LONG   = 3'd1;
    localparam logic [2:0] VERDICT_TOO_SHORT  = 3'd2;
    localparam logic [2:0] VERDICT_WRONG_ADDR = 3'd3;
    localparam logic [2:0] VERDICT_WRONG_TYPE = 3'd4;

    // Configuration register indices.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd1;

    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 14'd60;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 14'd1518;
    localparam logic [LEN_W-1:0] COUNT_MAX     = 14'h3FFF;

    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_PTP  = 16'h88F7;

    localparam logic [4:0] HDR_UNTAGGED = 5'd14;
    localparam logic [4:0] HDR_TAGGED   = 5'd18;

    // Byte positions of the EtherType fields.
    localparam logic [LEN_W-1:0] POS_OUTER_HI = 14'd12;
    localparam logic [LEN_W-1:0] POS_OUTER_LO = 14'd13;
    localparam logic [LEN_W-1:0] POS_INNER_HI = 14'd16;
    localparam logic [LEN_W-1:0] POS_INNER_LO = 14'd17;
    localparam logic [LEN_W-1:0] MAC_BYTES    = 14'd6;

    // Multicast addresses, element 0 is the first byte on the wire.
    localparam logic [5:0][7:0] PEER_MAC =
        {8'h0E, 8'h00, 8'h00, 8'hC2, 8'h80, 8'h01};
    localparam logic [5:0][7:0] DFLT_MAC =
        {8'h00, 8'h00, 8'h00, 8'h19, 8'h1B, 8'h01};

endpackage

[hw/rtl/ptp_layer2_frame_filter.sv]
// ----------------------------------------------------------------------------
// PTP layer-2 receive frame filter
// Classifies a received Ethernet frame, streamed one byte per transfer, as a
// PTP-over-Ethernet frame or not, and reports header offset and lengths.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_ready | t_in_item  (byte, last)
//   out     | output    | o_out_valid/ i_out_ready| t_out_item (verdict ...)
//   cfg     | input     | i_cfg_valid/ o_cfg_ready| index + 14-bit length
//
// One byte is taken every cycle while o_in_ready is high. The running
// frame state (byte counter, address match flags and the two EtherType
// fields) is updated from each byte in the cycle it is accepted; on the
// final byte the verdict is worked out in that same cycle and loaded into
// the result register, so a frame's result is presented in the cycle
// after its last byte is transferred. The input is ready whenever the
// result register is empty or its result is taken in the same cycle, so a
// waiting result that the receiver holds off stalls every byte, final or
// not. Reset (synchronous, active low) restores the length limits to 60
// and 1518 and clears the frame state; the config port is always ready.
//
module ptp_layer2_frame_filter #(
    parameter int RECV_WINDOW = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  ptpl2ff_pkg::t_in_item  i_in_data,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output ptpl2ff_pkg::t_out_item o_out_data,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptpl2ff_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ptpl2ff_pkg::LEN_W-1:0]       i_cfg_data
);
    import ptpl2ff_pkg::*;

`include "ptp_layer2_frame_filter_defines.svh"

    // The receive buffer window as a length value.
    localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(RECV_WINDOW);

    // Length limits written through the config port.
    logic [LEN_W-1:0] r_min_len;
    logic [LEN_W-1:0] r_max_len;

    // Per-frame state.
    logic [LEN_W-1:0] r_count,      n_count;
    logic             r_peer_match, n_peer_match;
    logic             r_dflt_match, n_dflt_match;
    logic [15:0]      r_outer_type, n_outer_type;
    logic [15:0]      r_inner_type, n_inner_type;

    // Result register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data,  n_out_data;

    logic in_accept;
    logic frame_end;

    // Verdict terms.
    logic             is_tagged;
    logic [15:0]      sel_type;
    logic [LEN_W-1:0] win_len;
    logic [2:0]       verdict;
    logic [4:0]       offset;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign frame_end   = in_accept && i_in_data.last_byte;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Configuration registers. Writes to unused indices are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_FRAME_LEN: r_min_len <= i_cfg_data;
                CFG_MAX_FRAME_LEN: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame state update from the accepted byte. The byte position is the
    // count before this byte; the counter sticks at its maximum.
    // ------------------------------------------------------------------
    always_comb begin
        n_peer_match = r_peer_match;
        n_dflt_match = r_dflt_match;
        n_outer_type = r_outer_type;
        n_inner_type = r_inner_type;
        n_count      = (r_count != COUNT_MAX) ? r_count + LEN_W'(1) : r_count;

        if (r_count < MAC_BYTES) begin
            if (i_in_data.data_byte != PEER_MAC[r_count[2:0]]) begin
                n_peer_match = 1'b0;
            end
            if (i_in_data.data_byte != DFLT_MAC[r_count[2:0]]) begin
                n_dflt_match = 1'b0;
            end
        end else if (r_count == POS_OUTER_HI) begin
            n_outer_type[15:8] = i_in_data.data_byte;
        end else if (r_count == POS_OUTER_LO) begin
            n_outer_type[7:0] = i_in_data.data_byte;
        end else if (r_count == POS_INNER_HI) begin
            n_inner_type[15:8] = i_in_data.data_byte;
        end else if (r_count == POS_INNER_LO) begin
            n_inner_type[7:0] = i_in_data.data_byte;
        end
    end

    // ------------------------------------------------------------------
    // Verdict, taken from the state as it stands after the final byte.
    // The user must keep the window at least 18 bytes (the block does not check
    // this), so the header-length checks can be made against the frame length.
    // ------------------------------------------------------------------
    assign win_len   = (n_count < WIN_LEN) ? n_count : WIN_LEN;
    assign is_tagged = (n_outer_type == TYPE_VLAN);
    assign sel_type  = is_tagged ? n_inner_type : n_outer_type;
    assign offset    = is_tagged ? HDR_TAGGED : HDR_UNTAGGED;

    always_comb begin
        if (n_count > r_max_len) begin
            verdict = VERDICT_TOO_LONG;
        end else if (n_count < r_min_len || n_count < LEN_W'(HDR_UNTAGGED)) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (!n_peer_match && !n_dflt_match) begin
            verdict = VERDICT_WRONG_ADDR;
        end else if (is_tagged && n_count < LEN_W'(HDR_TAGGED)) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (sel_type != TYPE_PTP) begin
            verdict = VERDICT_WRONG_TYPE;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

    always_comb begin
        n_out_data.verdict      = verdict;
        n_out_data.frame_length = n_count;
        if (verdict == VERDICT_ACCEPT) begin
            n_out_data.to_peer_address = n_peer_match;
            n_out_data.vlan_tagged     = is_tagged;
            n_out_data.ether_type      = sel_type;
            n_out_data.payload_offset  = offset;
            n_out_data.payload_length  = win_len[6:0] - {2'b00, offset};
        end else begin
            n_out_data.to_peer_address = 1'b0;
            n_out_data.vlan_tagged     = 1'b0;
            n_out_data.ether_type      = 16'h0000;
            n_out_data.payload_offset  = 5'd0;
            n_out_data.payload_length  = 7'd0;
        end
    end

    always_comb begin
        if (frame_end) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Registers. The frame state returns to its cleared form after the
    // final byte, ready for the next frame in the following cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_peer_match <= 1'b1;
            r_dflt_match <= 1'b1;
            r_outer_type <= '0;
            r_inner_type <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (frame_end) begin
                r_count      <= '0;
                r_peer_match <= 1'b1;
                r_dflt_match <= 1'b1;
                r_outer_type <= '0;
                r_inner_type <= '0;
            end else if (in_accept) begin
                r_count      <= n_count;
                r_peer_match <= n_peer_match;
                r_dflt_match <= n_dflt_match;
                r_outer_type <= n_outer_type;
                r_inner_type <= n_inner_type;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_end) begin
            r_out_data <= n_out_data;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `PTPFF_ASSERT_NOW(a_result_from_last, o_out_valid && !$past(o_out_valid), $past(frame_end), "result appeared without a final byte")
    `PTPFF_ASSERT_NEXT(a_frame_cleared, frame_end, r_count == '0 && r_peer_match && r_dflt_match, "frame state not cleared after final byte")
    `PTPFF_ASSERT_NOW(a_accept_offset, o_out_valid && o_out_data.verdict == VERDICT_ACCEPT, o_out_data.payload_offset == HDR_UNTAGGED || o_out_data.payload_offset == HDR_TAGGED, "accepted frame with bad payload offset")
    `PTPFF_ASSERT_NOW(a_reject_clean, o_out_valid && o_out_data.verdict != VERDICT_ACCEPT, o_out_data.ether_type == 16'h0000 && o_out_data.payload_offset == 5'd0 && !o_out_data.vlan_tagged, "rejected frame carries header fields")

endmodule
